### sv/rgb_pixel_blend_unit_assert.svh
// Assertion macros for the pixel blend unit checker.
// Depends on nothing; the including module must provide clk and arst_n.
`ifndef RGB_PIXEL_BLEND_UNIT_ASSERT_SVH
`define RGB_PIXEL_BLEND_UNIT_ASSERT_SVH

// Concurrent assertion sampled on the rising clock edge, off while in reset.
`define RPB_ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Concurrent assertion that also holds while reset is asserted.
`define RPB_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/rpb_pkg.sv
// Shared types, constants and helper functions for the pixel blend unit.
// Used by rpb_lane, rgb_pixel_blend_unit and rpb_checker; depends on nothing.
package rpb_pkg;

	localparam int unsigned CMD_W       = 4;
	localparam int unsigned CHAN_W      = 8;
	localparam int unsigned TGT_W       = 2;
	localparam int unsigned AMT_W       = 9;
	localparam int unsigned OPND_W      = 10;
	localparam int unsigned PROD_W      = 2 * OPND_W;
	localparam int unsigned DIV_IN_W    = 16;
	localparam int unsigned DIV_MUL_W   = 2 * DIV_IN_W;
	localparam int unsigned DIV_SHIFT   = 23;
	localparam int unsigned S_TDATA_W   = 56;
	localparam int unsigned M_TDATA_W   = 24;
	localparam int unsigned CFG_IDX_W   = 1;

	// floor(x / 255) == (x * 0x8081) >> 23 for every 16-bit x.
	localparam logic [DIV_IN_W-1:0] DIV255_MAGIC = 16'h8081;
	localparam logic [DIV_IN_W-1:0] ROUND_HALF   = 16'd127;
	localparam logic [CHAN_W-1:0]   CHAN_MAX     = 8'd255;
	localparam logic [CHAN_W-1:0]   OVL_LOW_MAX  = 8'd127;

	// Blend commands.
	typedef enum logic [CMD_W-1:0] {
		CMD_MUL     = 4'd0,
		CMD_SCREEN  = 4'd1,
		CMD_SUB     = 4'd2,
		CMD_ADD     = 4'd3,
		CMD_OVERLAY = 4'd4,
		CMD_ADDCH   = 4'd5,
		CMD_SCALECH = 4'd6,
		CMD_EXTRACT = 4'd7,
		CMD_ISOLATE = 4'd8
	} cmd_t;

	// Target channel codes.
	typedef enum logic [TGT_W-1:0] {
		TGT_BLUE  = 2'd0,
		TGT_GREEN = 2'd1,
		TGT_RED   = 2'd2,
		TGT_NONE  = 2'd3
	} tgt_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET = 1'b0,
		REG_AMOUNT = 1'b1
	} reg_idx_t;

	// What the last stage of a lane does with the product.
	typedef enum logic [1:0] {
		K_PASS  = 2'd0,
		K_DIV   = 2'd1,
		K_SCALE = 2'd2
	} kind_t;

	// Per-stage load enables handed from the top level to the lanes.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

	// Clamp a small signed sum to 0..255.
	function automatic logic [CHAN_W-1:0] sat_sum(input logic signed [OPND_W-1:0] v);
		logic [CHAN_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > $signed({2'b00, CHAN_MAX})) begin
			r = CHAN_MAX;
		end else begin
			r = v[CHAN_W-1:0];
		end
		return r;
	endfunction

	// Clamp a signed product to 0..255.
	function automatic logic [CHAN_W-1:0] sat_prod(input logic signed [PROD_W-1:0] v);
		logic [CHAN_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > $signed({{(PROD_W-CHAN_W){1'b0}}, CHAN_MAX})) begin
			r = CHAN_MAX;
		end else begin
			r = v[CHAN_W-1:0];
		end
		return r;
	endfunction

endpackage

### sv/rpb_lane.sv
// One color channel of the blend pipeline: operand select, multiply, then
// rounded divide by 255, saturation or pass-through. Depends on rpb_pkg.
module rpb_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rpb_pkg::stage_en_t            en,
	input  logic [rpb_pkg::CMD_W-1:0]     cmd,
	input  logic                          ch_valid,
	input  logic                          is_target,
	input  logic [rpb_pkg::CHAN_W-1:0]    a,
	input  logic [rpb_pkg::CHAN_W-1:0]    b,
	input  logic [rpb_pkg::CHAN_W-1:0]    ft,
	input  logic signed [rpb_pkg::AMT_W-1:0] amount,
	output logic [rpb_pkg::CHAN_W-1:0]    res_s3
);
	import rpb_pkg::*;

	kind_t                     kind_d;
	logic signed [OPND_W-1:0]  opa_d;
	logic signed [OPND_W-1:0]  opb_d;
	logic                      inv_d;
	logic [CHAN_W-1:0]         pass_d;
	logic signed [OPND_W-1:0]  diff;
	logic signed [OPND_W-1:0]  sum;
	logic signed [OPND_W-1:0]  sum_amt;

	kind_t                     kind_s1;
	logic signed [OPND_W-1:0]  opa_s1;
	logic signed [OPND_W-1:0]  opb_s1;
	logic                      inv_s1;
	logic [CHAN_W-1:0]         pass_s1;

	kind_t                     kind_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	logic                      inv_s2;
	logic [CHAN_W-1:0]         pass_s2;

	logic [DIV_IN_W-1:0]       rounded;
	logic [DIV_MUL_W-1:0]      scaled;
	logic [CHAN_W-1:0]         quot;
	logic [CHAN_W-1:0]         res_d;

	assign diff    = $signed({2'b00, a}) - $signed({2'b00, b});
	assign sum     = $signed({2'b00, a}) + $signed({2'b00, b});
	assign sum_amt = $signed({2'b00, a}) + OPND_W'(amount);

	// Stage one: pick multiplier operands or compute the pass-through value.
	always_comb begin
		kind_d = K_PASS;
		opa_d  = $signed({2'b00, a});
		opb_d  = $signed({2'b00, b});
		inv_d  = 1'b0;
		pass_d = a;
		case (cmd)
			CMD_MUL: begin
				kind_d = K_DIV;
			end
			CMD_SCREEN: begin
				kind_d = K_DIV;
				opa_d  = $signed({2'b00, ~a});
				opb_d  = $signed({2'b00, ~b});
				inv_d  = 1'b1;
			end
			CMD_SUB: begin
				pass_d = sat_sum(diff);
			end
			CMD_ADD: begin
				pass_d = sat_sum(sum);
			end
			CMD_OVERLAY: begin
				kind_d = K_DIV;
				if (b <= OVL_LOW_MAX) begin
					opa_d = $signed({1'b0, a, 1'b0});
				end else begin
					opa_d = $signed({1'b0, ~a, 1'b0});
					opb_d = $signed({2'b00, ~b});
					inv_d = 1'b1;
				end
			end
			CMD_ADDCH: begin
				if (ch_valid && is_target) begin
					pass_d = sat_sum(sum_amt);
				end
			end
			CMD_SCALECH: begin
				if (ch_valid && is_target) begin
					kind_d = K_SCALE;
					opb_d  = OPND_W'(amount);
				end
			end
			CMD_EXTRACT: begin
				if (ch_valid) begin
					pass_d = ft;
				end
			end
			CMD_ISOLATE: begin
				if (ch_valid && !is_target) begin
					pass_d = '0;
				end
			end
			default: begin
				pass_d = a;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			kind_s1 <= kind_d;
			opa_s1  <= opa_d;
			opb_s1  <= opb_d;
			inv_s1  <= inv_d;
			pass_s1 <= pass_d;
		end
	end

	// Stage two: the one signed multiply.
	always_ff @(posedge clk) begin
		if (en.s2) begin
			kind_s2 <= kind_s1;
			prod_s2 <= opa_s1 * opb_s1;
			inv_s2  <= inv_s1;
			pass_s2 <= pass_s1;
		end
	end

	// Stage three: round and divide by 255 through a reciprocal multiply.
	assign rounded = prod_s2[DIV_IN_W-1:0] + ROUND_HALF;
	assign scaled  = DIV_MUL_W'(rounded) * DIV_MUL_W'(DIV255_MAGIC);
	assign quot    = scaled[DIV_SHIFT +: CHAN_W];

	always_comb begin
		case (kind_s2)
			K_DIV:   res_d = inv_s2 ? (CHAN_MAX - quot) : quot;
			K_SCALE: res_d = sat_prod(prod_s2);
			default: res_d = pass_s2;
		endcase
	end

	// The result register is cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s3 <= '0;
		end else if (en.s3) begin
			res_s3 <= res_d;
		end
	end

endmodule

### sv/rgb_pixel_blend_unit.sv
// Top level of the pixel blend unit: stream ports, configuration registers,
// pipeline valid/ready control and three channel lanes. Depends on rpb_pkg, rpb_lane.
//
// Channel   Dir  Signals                       Transaction
// s_*       in   s_tvalid s_tready s_tdata     one command and pixel pair
// m_*       out  m_tvalid m_tready m_tdata     one blended pixel
// cfg_*     in   cfg_valid cfg_ready cfg_index cfg_data   one register write
//
// One pixel enters per clock while the output is not stalled; each result passes
// through the three register stages: operand select, multiply, divide by 255.
// Each stage holds its own valid bit and advances when the stage after it is
// empty or moving, so bubbles close up while the output is stalled.
// Reset clears the valid bits and the configuration registers.
// The configuration port is always ready.
module rgb_pixel_blend_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// command[3:0], first_blue[11:4], first_green[19:12], first_red[27:20],
	// second_blue[35:28], second_green[43:36], second_red[51:44], zero pad
	input  logic [rpb_pkg::S_TDATA_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// out_blue[7:0], out_green[15:8], out_red[23:16]
	output logic [rpb_pkg::M_TDATA_W-1:0]   m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rpb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rpb_pkg::AMT_W-1:0]       cfg_data
);
	import rpb_pkg::*;

	localparam int unsigned NCH = 3;

	logic [TGT_W-1:0]         target_q;
	logic signed [AMT_W-1:0]  amount_q;
	logic                     v_s1;
	logic                     v_s2;
	logic                     v_s3;
	stage_en_t                en;
	logic [CMD_W-1:0]         cmd;
	logic [CHAN_W-1:0]        first_px [NCH];
	logic [CHAN_W-1:0]        second_px [NCH];
	logic [CHAN_W-1:0]        ft;
	logic                     ch_valid;
	logic [CHAN_W-1:0]        res [NCH];

	// Unpack the input transaction.
	assign cmd = s_tdata[CMD_W-1:0];
	always_comb begin
		for (int i = 0; i < NCH; i++) begin
			first_px[i]  = s_tdata[CMD_W + i*CHAN_W +: CHAN_W];
			second_px[i] = s_tdata[CMD_W + (NCH+i)*CHAN_W +: CHAN_W];
		end
	end

	// Configuration registers.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TGT_BLUE;
			amount_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TARGET: target_q <= cfg_data[TGT_W-1:0];
				REG_AMOUNT: amount_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// Target channel of the first pixel, used by extract.
	always_comb begin
		case (target_q)
			TGT_GREEN: ft = first_px[1];
			TGT_RED:   ft = first_px[2];
			default:   ft = first_px[0];
		endcase
	end
	assign ch_valid = (target_q != TGT_NONE);

	// Stage enables: a stage loads when it is empty or the next one loads.
	assign en.s3    = !v_s3 || m_tready;
	assign en.s2    = !v_s2 || en.s3;
	assign en.s1    = !v_s1 || en.s2;
	assign s_tready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en.s1) begin
				v_s1 <= s_tvalid;
			end
			if (en.s2) begin
				v_s2 <= v_s1;
			end
			if (en.s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// One lane per color channel.
	for (genvar g = 0; g < NCH; g++) begin : g_lane
		rpb_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.cmd       (cmd),
			.ch_valid  (ch_valid),
			.is_target (target_q == TGT_W'(g)),
			.a         (first_px[g]),
			.b         (second_px[g]),
			.ft        (ft),
			.amount    (amount_q),
			.res_s3    (res[g])
		);
	end

	// Pack the output transaction.
	assign m_tvalid = v_s3;
	always_comb begin
		for (int i = 0; i < NCH; i++) begin
			m_tdata[i*CHAN_W +: CHAN_W] = res[i];
		end
	end

endmodule

### sv/rpb_checker.sv
// Port-level checker for the pixel blend unit, bound to the top level.
// Depends on rpb_pkg and the macros in rgb_pixel_blend_unit_assert.svh.
`include "rgb_pixel_blend_unit_assert.svh"

module rpb_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [rpb_pkg::M_TDATA_W-1:0]   m_tdata,
	input  logic                            cfg_ready
);
	import rpb_pkg::*;

	// A stalled result keeps its value.
	`RPB_ASSERT_CLK(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")

	// Input back-pressure only appears when the output is full and stalled.
	`RPB_ASSERT_CLK(a_bp_cause, !s_tready |-> (m_tvalid && !m_tready), "input stalled without output stall")

	// An accepted transaction reaches the output when the output is not stalled on the way.
	`RPB_ASSERT_CLK(a_latency, (s_tvalid && s_tready) ##1 m_tready ##1 m_tready |=> m_tvalid, "result missing after pipeline latency")

	// The configuration channel never pushes back.
	`RPB_ASSERT_ALWAYS(a_cfg_ready, cfg_ready, "configuration port not ready")

endmodule

bind rgb_pixel_blend_unit rpb_checker u_rpb_checker (.*);

### sim/rpb_blend_checker.sv
`timescale 1ns / 100ps
// Checker for the pixel blend unit. It follows the configuration, input and output
// channels, predicts each blended pixel and compares it with the block's result.
// Depends on rpb_pkg.
module rpb_blend_checker
	import rpb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [M_TDATA_W-1:0]  m_tdata,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [AMT_W-1:0]      cfg_data,
	output int                    mismatch_count,
	output int                    pixels_in_flight,
	output int                    pixels_checked
);

	localparam int REPORT_LIMIT = 10;
	localparam int FULL_SCALE   = 255;
	localparam int ROUND_BIAS   = 127;
	localparam int OVL_LOW_TOP  = 127;

	// One input transaction: command in the lowest bits, then the two pixels.
	typedef struct packed {
		logic [S_TDATA_W-6*CHAN_W-CMD_W-1:0] pad;
		logic [CHAN_W-1:0]                   second_red;
		logic [CHAN_W-1:0]                   second_green;
		logic [CHAN_W-1:0]                   second_blue;
		logic [CHAN_W-1:0]                   first_red;
		logic [CHAN_W-1:0]                   first_green;
		logic [CHAN_W-1:0]                   first_blue;
		logic [CMD_W-1:0]                    command;
	} pixel_pair_t;

	// One output transaction, blue in the lowest byte.
	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} bgr_pixel_t;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		bgr_pixel_t       pixel;
	} blend_result_t;

	// Clamp a signed value to one channel byte.
	function automatic logic [CHAN_W-1:0] clamp_byte(input int v);
		if (v < 0) begin
			return '0;
		end
		if (v > FULL_SCALE) begin
			return CHAN_MAX;
		end
		return v[CHAN_W-1:0];
	endfunction

	// Divide by 255 with round to nearest.
	function automatic logic [CHAN_W-1:0] div255_round(input int v);
		return CHAN_W'((v + ROUND_BIAS) / FULL_SCALE);
	endfunction

	// Two-layer blend of one channel.
	function automatic logic [CHAN_W-1:0] blend_channel(input logic [CMD_W-1:0] op,
			input int a, input int b);
		logic [CHAN_W-1:0] r;
		case (op)
			CMD_MUL:    r = div255_round(a * b);
			CMD_SCREEN: r = CHAN_W'(FULL_SCALE - div255_round((FULL_SCALE - a) * (FULL_SCALE - b)));
			CMD_SUB:    r = clamp_byte(a - b);
			CMD_ADD:    r = clamp_byte(a + b);
			default: begin
				// Overlay splits on the top layer value.
				if (b <= OVL_LOW_TOP) begin
					r = div255_round(2 * a * b);
				end else begin
					r = CHAN_W'(FULL_SCALE
						- div255_round(2 * (FULL_SCALE - a) * (FULL_SCALE - b)));
				end
			end
		endcase
		return r;
	endfunction

	// Whole-pixel result for one command under the current register values.
	function automatic bgr_pixel_t blend_pixel(input pixel_pair_t p, input tgt_t tgt,
			input int amount);
		logic [CHAN_W-1:0] base [3];
		logic [CHAN_W-1:0] over [3];
		logic [CHAN_W-1:0] res  [3];
		int                ch;
		bgr_pixel_t        px;
		base = '{p.first_blue, p.first_green, p.first_red};
		over = '{p.second_blue, p.second_green, p.second_red};
		res  = base;
		ch   = int'(tgt);
		if (p.command <= CMD_OVERLAY) begin
			for (int i = 0; i < 3; i++) begin
				res[i] = blend_channel(p.command, base[i], over[i]);
			end
		end else if (p.command <= CMD_ISOLATE && tgt != TGT_NONE) begin
			// Channel commands look at the base pixel only.
			case (p.command)
				CMD_ADDCH:   res[ch] = clamp_byte(int'(base[ch]) + amount);
				CMD_SCALECH: res[ch] = clamp_byte(int'(base[ch]) * amount);
				CMD_EXTRACT: res = '{base[ch], base[ch], base[ch]};
				default: begin
					for (int i = 0; i < 3; i++) begin
						res[i] = (i == ch) ? base[i] : '0;
					end
				end
			endcase
		end
		// Unknown commands and a missing target leave the base pixel as it is.
		px.blue  = res[0];
		px.green = res[1];
		px.red   = res[2];
		return px;
	endfunction

	tgt_t                     target_sel = TGT_BLUE;
	logic signed [AMT_W-1:0]  amount_sel = '0;
	blend_result_t            awaited_pixels [$];
	blend_result_t            oldest;
	blend_result_t            fresh;
	pixel_pair_t              pair;
	bgr_pixel_t               got;
	int                       errors  = 0;
	int                       checked = 0;

	// Follow every transaction on the three channels at the rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_sel = TGT_BLUE;
			amount_sel = '0;
			awaited_pixels.delete();
		end else begin
			// The bench must write registers only while the pipeline is empty; this checker does not enforce it.
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_TARGET: target_sel = tgt_t'(cfg_data[TGT_W-1:0]);
					REG_AMOUNT: amount_sel = cfg_data;
					default:    ;
				endcase
			end

			// Compare a leaving pixel with the oldest prediction.
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				checked++;
				if (awaited_pixels.size() == 0) begin
					errors++;
					if (errors <= REPORT_LIMIT) begin
						$display("%0t: result with nothing awaited: B %0d G %0d R %0d",
							$realtime, got.blue, got.green, got.red);
					end
				end else begin
					oldest = awaited_pixels.pop_front();
					if (got.blue !== oldest.pixel.blue || got.green !== oldest.pixel.green
							|| got.red !== oldest.pixel.red) begin
						errors++;
						if (errors <= REPORT_LIMIT) begin
							$display("%0t: command %0d expected B %0d G %0d R %0d, got B %0d G %0d R %0d",
								$realtime, oldest.command, oldest.pixel.blue,
								oldest.pixel.green, oldest.pixel.red,
								got.blue, got.green, got.red);
						end
					end
				end
			end

			// Predict the result of an entering pixel pair and queue it at the tail.
			if (s_tvalid && s_tready) begin
				pair           = s_tdata;
				fresh.command  = pair.command;
				fresh.pixel    = blend_pixel(pair, target_sel, int'(amount_sel));
				awaited_pixels = {awaited_pixels, fresh};
			end
		end
		mismatch_count   <= errors;
		pixels_in_flight <= awaited_pixels.size();
		pixels_checked   <= checked;
	end

endmodule

### sim/tb_rgb_pixel_blend_unit.sv
`timescale 1ns / 100ps
// Testbench top for the pixel blend unit: clock, reset, stimulus, output stalls and verdict.
// Depends on rpb_pkg, rgb_pixel_blend_unit and rpb_blend_checker.
module tb_rgb_pixel_blend_unit;
	import rpb_pkg::*;

	localparam int               CLK_HALF         = 4;
	localparam int               RESET_CYCLES     = 12;
	localparam int               STALL_LIMIT      = 1000;
	localparam int               HOLD_OFF_CYCLES  = 64;
	localparam int               DRAIN_PAUSE      = 8;
	localparam int               RANDOM_PER_PHASE = 103;
	localparam int               RANDOM_SETTINGS  = 5;
	localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 4'd9;
	localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 4'd15;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	// command, first blue, green, red, second blue, green, red, zero pad
	logic [S_TDATA_W-1:0]  s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	// out blue, out green, out red
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_TARGET;
	logic [AMT_W-1:0]      cfg_data  = '0;

	int                    mismatch_count;
	int                    pixels_in_flight;
	int                    pixels_checked;
	int                    quiet_cycles   = 0;
	int                    settings_used  = 0;
	bit                    source_idles   = 1'b0;
	bit                    sink_idles     = 1'b0;
	bit                    hold_off_req   = 1'b0;

	rgb_pixel_blend_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	rpb_blend_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.mismatch_count   (mismatch_count),
		.pixels_in_flight (pixels_in_flight),
		.pixels_checked   (pixels_checked)
	);

	always #(CLK_HALF) clk = ~clk;

	// Watchdog: too long without any transaction ends the run.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Idle length: mostly none, sometimes short, rarely long.
	function automatic int gap_cycles();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 65) begin
			return 0;
		end
		if (pick < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// Channel level with extra weight on the ends and the overlay split.
	function automatic logic [CHAN_W-1:0] pick_level();
		case ($urandom_range(0, 9))
			0:       return 8'd0;
			1:       return 8'd255;
			2:       return 8'd127;
			3:       return 8'd128;
			default: return CHAN_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Offer one pixel pair and wait until it is taken.
	task automatic offer_pixel(input logic [CMD_W-1:0] cmd,
			input logic [CHAN_W-1:0] fb, input logic [CHAN_W-1:0] fg,
			input logic [CHAN_W-1:0] fr, input logic [CHAN_W-1:0] sb,
			input logic [CHAN_W-1:0] sg, input logic [CHAN_W-1:0] sr);
		int gap;
		gap = source_idles ? gap_cycles() : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {{(S_TDATA_W - 6 * CHAN_W - CMD_W){1'b0}}, sr, sg, sb, fr, fg, fb, cmd};
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop offering and wait until every predicted pixel has come out.
	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		wait (pixels_in_flight == 0);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [AMT_W-1:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// New register values, written only once the block is empty.
	task automatic apply_setting(input tgt_t tgt, input int amount);
		drain();
		write_reg(REG_TARGET, AMT_W'(tgt));
		write_reg(REG_AMOUNT, AMT_W'(amount));
		settings_used++;
	endtask

	// The four channel commands on a pixel with distinct channels.
	task automatic run_channel_ops();
		for (int op = CMD_ADDCH; op <= CMD_ISOLATE; op++) begin
			offer_pixel(CMD_W'(op), 8'd10, 8'd128, 8'd255, 8'd255, 8'd0, 8'd255);
		end
	endtask

	task automatic run_random_pixels(input int count, input bit may_idle);
		logic [CMD_W-1:0] op;
		source_idles = may_idle && ($urandom_range(0, 3) != 0);
		sink_idles   = ($urandom_range(0, 3) != 0);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 9) == 0) begin
				op = CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
			end else begin
				op = CMD_W'($urandom_range(CMD_MUL, CMD_ISOLATE));
			end
			offer_pixel(op, pick_level(), pick_level(), pick_level(),
				pick_level(), pick_level(), pick_level());
		end
	endtask

	// Output side: random stalls, plus one long hold-off on request.
	initial begin : sink
		int stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_tready     = 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
			end else if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else begin
				m_tready   = 1'b1;
				stall_left = sink_idles ? gap_cycles() : 0;
			end
		end
	end

	initial begin : stimulus
		int tgt_pick;
		int amount_pick;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Two-layer blends at the channel corners and on both sides of the overlay split.
		for (int op = CMD_MUL; op <= CMD_OVERLAY; op++) begin
			offer_pixel(CMD_W'(op), 8'd0, 8'd255, 8'd128, 8'd255, 8'd255, 8'd127);
			offer_pixel(CMD_W'(op), 8'd255, 8'd0, 8'd200, 8'd0, 8'd128, 8'd128);
		end
		// Unknown commands pass the base pixel through.
		offer_pixel(CMD_UNUSED_FIRST, 8'd1, 8'd2, 8'd3, 8'd255, 8'd255, 8'd255);
		offer_pixel(CMD_UNUSED_LAST, 8'd255, 8'd170, 8'd85, 8'd0, 8'd0, 8'd0);

		// Channel commands saturating high, saturating low, and with no target.
		apply_setting(TGT_RED, 255);
		run_channel_ops();
		apply_setting(TGT_GREEN, -256);
		run_channel_ops();
		apply_setting(TGT_NONE, 1);
		run_channel_ops();

		// Long output hold-off while the source streams without gaps.
		apply_setting(TGT_BLUE, -1);
		hold_off_req = 1'b1;
		run_random_pixels(RANDOM_PER_PHASE, 1'b0);

		apply_setting(TGT_GREEN, 255);
		run_random_pixels(RANDOM_PER_PHASE, 1'b1);
		apply_setting(TGT_RED, -256);
		run_random_pixels(RANDOM_PER_PHASE, 1'b1);

		// Random register values, now and then at the amount extremes.
		for (int n = 0; n < RANDOM_SETTINGS; n++) begin
			tgt_pick = $urandom_range(TGT_BLUE, TGT_NONE);
			case ($urandom_range(0, 5))
				0:       amount_pick = -256;
				1:       amount_pick = 255;
				default: amount_pick = $urandom_range(0, 511) - 256;
			endcase
			apply_setting(tgt_t'(tgt_pick), amount_pick);
			run_random_pixels(RANDOM_PER_PHASE, 1'b1);
		end

		drain();
		repeat (DRAIN_PAUSE) @(posedge clk);
		$display("Checked %0d blended pixels over %0d register settings,", pixels_checked,
			settings_used);
		$display("all nine commands, unknown codes, saturation and a long output stall.");
		if (mismatch_count == 0 && pixels_in_flight == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

### rgb_pixel_blend_unit.f
+incdir+sv
sv/rpb_pkg.sv
sv/rpb_lane.sv
sv/rgb_pixel_blend_unit.sv
sv/rpb_checker.sv
sim/rpb_blend_checker.sv
sim/tb_rgb_pixel_blend_unit.sv
